FILE: hw/rtl/morse_char_keyer_defines.svh
// Assertion helpers for the Morse keyer. Each expects clk_i and rst_ni in scope.
`ifndef MORSE_CHAR_KEYER_DEFINES_SVH
`define MORSE_CHAR_KEYER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyer check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyer check failed");

`endif

FILE: hw/rtl/mck_pkg.sv
package mck_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned SymW   = 6;
  localparam int unsigned LenW   = 3;
  localparam int unsigned MaxEl  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] DotReset   = 24'd200000;
  localparam logic [TimeW-1:0] DashReset  = 24'd600000;
  localparam logic [TimeW-1:0] SpaceReset = 24'd500000;

  localparam logic [7:0] AsciiSpace  = 8'h20;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiNine   = 8'h39;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5a;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerZ = 8'h7a;
  localparam logic [7:0] CaseOffset  = 8'h20;
  localparam logic [7:0] DigitBase   = 8'd26;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DOT   = 2'd0,
    REG_DASH  = 2'd1,
    REG_SPACE = 2'd2
  } mck_reg_e;

  // What an incoming byte means.
  typedef enum logic [1:0] {
    CH_NONE,
    CH_SPACE,
    CH_SYM
  } mck_kind_e;

  // Kind of segment the datapath places in the output register.
  typedef enum logic [1:0] {
    SEG_ELEM,
    SEG_GAP,
    SEG_TAIL,
    SEG_SPACE
  } mck_seg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_GAP,
    ST_TAIL,
    ST_SPACE
  } mck_state_e;

  typedef struct packed {
    mck_kind_e       kind;
    logic [SymW-1:0] sym;
  } mck_char_t;

  // Element count and dash mask, element 0 in the lowest bit.
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [MaxEl-1:0] dash;
  } mck_pat_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic     load_char;
    logic     seg_load;
    mck_seg_e seg_kind;
    logic     elem_inc;
  } mck_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    mck_kind_e in_kind;
    logic      elem_last;
    logic      out_free;
  } mck_stat_t;

  // Fold case and sort a byte into space, symbol or nothing.
  function automatic mck_char_t classify(input logic [7:0] c);
    logic [7:0] u;
    mck_char_t  r;
    u = c;
    if (c >= AsciiLowerA && c <= AsciiLowerZ) begin
      u = c - CaseOffset;
    end
    r.kind = CH_NONE;
    r.sym  = '0;
    if (u == AsciiSpace) begin
      r.kind = CH_SPACE;
    end else if (u >= AsciiUpperA && u <= AsciiUpperZ) begin
      r.kind = CH_SYM;
      r.sym  = SymW'(u - AsciiUpperA);
    end else if (u >= AsciiZero && u <= AsciiNine) begin
      r.kind = CH_SYM;
      r.sym  = SymW'(u - AsciiZero + DigitBase);
    end
    return r;
  endfunction

  // International Morse table: letters A to Z, then digits 0 to 9.
  function automatic mck_pat_t morse_pattern(input logic [SymW-1:0] sym);
    mck_pat_t p;
    unique case (sym)
      6'd0:  p = '{3'd2, 5'b00010};
      6'd1:  p = '{3'd4, 5'b00001};
      6'd2:  p = '{3'd4, 5'b00101};
      6'd3:  p = '{3'd3, 5'b00001};
      6'd4:  p = '{3'd1, 5'b00000};
      6'd5:  p = '{3'd4, 5'b00100};
      6'd6:  p = '{3'd3, 5'b00011};
      6'd7:  p = '{3'd4, 5'b00000};
      6'd8:  p = '{3'd2, 5'b00000};
      6'd9:  p = '{3'd4, 5'b01110};
      6'd10: p = '{3'd3, 5'b00101};
      6'd11: p = '{3'd4, 5'b00010};
      6'd12: p = '{3'd2, 5'b00011};
      6'd13: p = '{3'd2, 5'b00001};
      6'd14: p = '{3'd3, 5'b00111};
      6'd15: p = '{3'd4, 5'b00110};
      6'd16: p = '{3'd4, 5'b01011};
      6'd17: p = '{3'd3, 5'b00010};
      6'd18: p = '{3'd3, 5'b00000};
      6'd19: p = '{3'd1, 5'b00001};
      6'd20: p = '{3'd3, 5'b00100};
      6'd21: p = '{3'd4, 5'b01000};
      6'd22: p = '{3'd3, 5'b00110};
      6'd23: p = '{3'd4, 5'b01001};
      6'd24: p = '{3'd4, 5'b01101};
      6'd25: p = '{3'd4, 5'b00011};
      6'd26: p = '{3'd5, 5'b11111};
      6'd27: p = '{3'd5, 5'b11110};
      6'd28: p = '{3'd5, 5'b11100};
      6'd29: p = '{3'd5, 5'b11000};
      6'd30: p = '{3'd5, 5'b10000};
      6'd31: p = '{3'd5, 5'b00000};
      6'd32: p = '{3'd5, 5'b00001};
      6'd33: p = '{3'd5, 5'b00011};
      6'd34: p = '{3'd5, 5'b00111};
      6'd35: p = '{3'd5, 5'b01111};
      default: p = '{3'd1, 5'b00000};
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/mck_ctrl.sv
module mck_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mck_pkg::mck_stat_t   stat_i,
  output mck_pkg::mck_cmd_t    cmd_o
);

  mck_pkg::mck_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mck_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. Each segment state waits until the output register can take a word.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mck_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.in_kind)
            mck_pkg::CH_SPACE: state_d = mck_pkg::ST_SPACE;
            mck_pkg::CH_SYM:   state_d = mck_pkg::ST_ELEM;
            default:           state_d = mck_pkg::ST_IDLE;
          endcase
        end
      end
      mck_pkg::ST_ELEM: begin
        if (stat_i.out_free) state_d = mck_pkg::ST_GAP;
      end
      mck_pkg::ST_GAP: begin
        if (stat_i.out_free) begin
          state_d = stat_i.elem_last ? mck_pkg::ST_TAIL : mck_pkg::ST_ELEM;
        end
      end
      mck_pkg::ST_TAIL: begin
        if (stat_i.out_free) state_d = mck_pkg::ST_IDLE;
      end
      mck_pkg::ST_SPACE: begin
        if (stat_i.out_free) state_d = mck_pkg::ST_IDLE;
      end
      default: state_d = mck_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load_char = 1'b0;
    cmd_o.seg_load  = 1'b0;
    cmd_o.seg_kind  = mck_pkg::SEG_ELEM;
    cmd_o.elem_inc  = 1'b0;
    unique case (state_q)
      mck_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_char = in_valid_i;
      end
      mck_pkg::ST_ELEM: begin
        cmd_o.seg_load = stat_i.out_free;
        cmd_o.seg_kind = mck_pkg::SEG_ELEM;
      end
      mck_pkg::ST_GAP: begin
        cmd_o.seg_load = stat_i.out_free;
        cmd_o.seg_kind = mck_pkg::SEG_GAP;
        cmd_o.elem_inc = stat_i.out_free && !stat_i.elem_last;
      end
      mck_pkg::ST_TAIL: begin
        cmd_o.seg_load = stat_i.out_free;
        cmd_o.seg_kind = mck_pkg::SEG_TAIL;
      end
      mck_pkg::ST_SPACE: begin
        cmd_o.seg_load = stat_i.out_free;
        cmd_o.seg_kind = mck_pkg::SEG_SPACE;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mck_dpath.sv
module mck_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     char_code_i,
  input  logic                           cfg_valid_i,
  input  logic [mck_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mck_pkg::TimeW-1:0]      cfg_data_i,
  input  mck_pkg::mck_cmd_t              cmd_i,
  output mck_pkg::mck_stat_t             stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           led_on_o,
  output logic [mck_pkg::TimeW-1:0]      duration_us_o,
  output logic                           last_o
);

  logic [mck_pkg::TimeW-1:0] dot_q, dash_q, space_q;
  logic [mck_pkg::LenW-1:0]  len_q;
  logic [mck_pkg::MaxEl-1:0] dash_mask_q;
  logic [mck_pkg::LenW-1:0]  elem_q, elem_d;
  logic                      ov_q, ov_d;
  logic                      led_q, led_d;
  logic [mck_pkg::TimeW-1:0] dur_q, dur_d;
  logic                      last_q, last_d;
  mck_pkg::mck_char_t        in_char;
  mck_pkg::mck_pat_t         in_pat;

  assign in_char = mck_pkg::classify(char_code_i);
  assign in_pat  = mck_pkg::morse_pattern(in_char.sym);

  // Timing registers; writes to an unused index fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= mck_pkg::DotReset;
      dash_q  <= mck_pkg::DashReset;
      space_q <= mck_pkg::SpaceReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mck_pkg::REG_DOT:   dot_q   <= cfg_data_i;
        mck_pkg::REG_DASH:  dash_q  <= cfg_data_i;
        mck_pkg::REG_SPACE: space_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pattern of the character in progress.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      len_q       <= in_pat.len;
      dash_mask_q <= in_pat.dash;
    end
  end

  // Element counter.
  always_comb begin
    elem_d = elem_q;
    if (cmd_i.load_char) begin
      elem_d = '0;
    end else if (cmd_i.elem_inc) begin
      elem_d = elem_q + 1'b1;
    end
  end

  // Segment values for the requested kind.
  always_comb begin
    led_d  = 1'b0;
    dur_d  = dot_q;
    last_d = 1'b0;
    unique case (cmd_i.seg_kind)
      mck_pkg::SEG_ELEM: begin
        led_d = 1'b1;
        dur_d = dash_mask_q[elem_q] ? dash_q : dot_q;
      end
      mck_pkg::SEG_GAP: begin
        dur_d = dot_q;
      end
      mck_pkg::SEG_TAIL: begin
        dur_d  = dash_q;
        last_d = 1'b1;
      end
      mck_pkg::SEG_SPACE: begin
        dur_d  = space_q;
        last_d = 1'b1;
      end
      default: dur_d = dot_q;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    ov_d = ov_q;
    if (cmd_i.seg_load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      elem_q <= '0;
    end else begin
      ov_q   <= ov_d;
      elem_q <= elem_d;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_load) begin
      led_q  <= led_d;
      dur_q  <= dur_d;
      last_q <= last_d;
    end
  end

  assign stat_o.in_kind   = in_char.kind;
  assign stat_o.elem_last = (elem_q == len_q - 1'b1);
  assign stat_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o   = ov_q;
  assign led_on_o      = led_q;
  assign duration_us_o = dur_q;
  assign last_o        = last_q;

endmodule

FILE: hw/rtl/morse_char_keyer.sv
// Morse character keyer.
// Slave stream: one ASCII byte per word in s_axis_tdata. Lower case folds to upper case.
// Master stream: one keying segment per word; tdata carries the level and the duration in
// microseconds, tlast marks the closing segment of a character.
// A letter or digit of n elements gives 2n+1 segments: on and gap for each element, then
// a dark segment of dash time. A space gives one dark segment of space time. Any other
// byte gives no word at all.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 dot, 1 dash, 2 space) and
// cfg_data_i; the port is always ready and index 3 is ignored. Write only while idle.
// Timing: a byte is accepted in the idle state; then, while the receiver takes every word,
// the controller loads one segment per cycle into the output register. The first segment
// is loaded in the element state entered after the byte is accepted. The next byte
// is taken once the closing segment sits in the output register, even while it waits there.
// A stalled receiver simply holds the output register and the controller waits on it.
// Reset clears the controller and the output register and restores the timing registers
// to 200000, 600000 and 500000 microseconds.
`include "morse_char_keyer_defines.svh"

module morse_char_keyer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] led_on, [24:1] duration_us, [31:25] zero
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mck_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mck_pkg::TimeW-1:0]   cfg_data_i
);

  mck_pkg::mck_cmd_t         cmd;
  mck_pkg::mck_stat_t        stat;
  logic                      led_on;
  logic [mck_pkg::TimeW-1:0] duration_us;
  logic                      in_acc;

  assign cfg_ready_o = 1'b1;

  mck_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mck_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .led_on_o      (led_on),
    .duration_us_o (duration_us),
    .last_o        (m_axis_tlast)
  );

  // Pack the output word, upper bits zero.
  assign m_axis_tdata = {7'd0, duration_us, led_on};

  // An input word is taken at this edge.
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Checks on the keyer's own sequencing.
  `MCK_ASSERT_NEXT(a_unmapped_stays_idle, in_acc && stat.in_kind == mck_pkg::CH_NONE, s_axis_tready)
  `MCK_ASSERT_NEXT(a_symbol_goes_busy, in_acc && stat.in_kind == mck_pkg::CH_SYM, !s_axis_tready)
  `MCK_ASSERT_NOW(a_closing_segment_dark, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0])

endmodule
